>>> hdl/ilir_pkg.sv
// Package for the indexed list core: sizes, operation and status codes,
// and the command struct broadcast to every storage cell.
// No dependencies; used by ilir_decode, ilir_cell and the top level.
package ilir_pkg;

  // List sizing
  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int WORD_W   = (DATA_W < 32) ? DATA_W : 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Port field widths
  localparam int FUNC_W   = 3;
  localparam int INDEX_W  = 16;
  localparam int VALUE_W  = 32;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_GET    = 3'd0;
  localparam logic [FUNC_W-1:0] OP_SET    = 3'd1;
  localparam logic [FUNC_W-1:0] OP_INSERT = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POP    = 3'd3;
  localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INDEX_TOO_BIG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL          = 2'd2;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY     = 2'd3;

  // Command seen by every cell in the same cycle
  typedef struct packed {
    logic              ins;   // shift right from pos, write word at pos
    logic              pop;   // shift left from pos
    logic              wr;    // overwrite entry at pos
    logic [IDX_W-1:0]  pos;   // effective position
    logic [WORD_W-1:0] word;  // data for insert or set
  } cell_cmd_t;

endpackage

>>> hdl/indexed_list_insert_remove_core.sv
// Indexed list core: a row of CAPACITY storage cells with shift insert and
// delete, the request decoder, the fill count and the result register.
// Depends on ilir_pkg, ilir_decode and ilir_cell.
//
// The block holds an ordered list of up to 16 words and takes one request
// per clock cycle: get, set, insert (shift right), pop (shift left) or clear.
// Every cell loads from its neighbor in the same cycle, so each request,
// including an insert or pop at the head, updates all cells at once and
// its result appears in the output register on the next cycle. The input
// is stalled only while a finished result sits in the output register and
// the receiving side stalls it. Storage needs no clearing after reset: only
// entries below the fill count are ever read.
module indexed_list_insert_remove_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ilir_pkg::FUNC_W-1:0]       in_func,
  input  logic [ilir_pkg::INDEX_W-1:0]      in_index,
  input  logic [ilir_pkg::VALUE_W-1:0]      in_value_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ilir_pkg::VALUE_W-1:0]      out_value_out,
  output logic [ilir_pkg::FILL_W-1:0]       out_fill_length,
  output logic [ilir_pkg::STATUS_W-1:0]     out_status
);

  logic                            accept;
  logic [ilir_pkg::CNT_W-1:0]      count_r;
  logic [ilir_pkg::CNT_W-1:0]      count_nxt;
  ilir_pkg::cell_cmd_t             cmd;
  logic                            rd_en;
  logic [ilir_pkg::STATUS_W-1:0]   status;
  logic [ilir_pkg::WORD_W-1:0]     cell_word [ilir_pkg::CAPACITY];
  logic [ilir_pkg::WORD_W-1:0]     cell_rd   [ilir_pkg::CAPACITY];
  logic [ilir_pkg::WORD_W-1:0]     rd_word;

  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic [ilir_pkg::VALUE_W-1:0]    out_value_r;
  logic [ilir_pkg::FILL_W-1:0]     out_fill_r;
  logic [ilir_pkg::STATUS_W-1:0]   out_status_r;

  // Stall a new request only while a result waits under stall
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  ilir_decode u_decode (
    .go        (accept),
    .func      (in_func),
    .index     (in_index),
    .value_in  (in_value_in),
    .count     (count_r),
    .cmd       (cmd),
    .rd_en     (rd_en),
    .status    (status),
    .count_nxt (count_nxt)
  );

  // Row of cells, each wired to its two neighbors
  for (genvar i = 0; i < ilir_pkg::CAPACITY; i++) begin : g_cell
    logic [ilir_pkg::WORD_W-1:0] left_w;
    logic [ilir_pkg::WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_word[i-1];
    end
    if (i == ilir_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[i+1];
    end
    ilir_cell u_cell (
      .clk        (clk),
      .cell_pos   (ilir_pkg::IDX_W'(i)),
      .cmd        (cmd),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .rd_word    (cell_rd[i])
    );
  end

  // Merge the selected cell's word
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < ilir_pkg::CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // Advance the fill count on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= rd_en ? ilir_pkg::VALUE_W'(rd_word) : '0;
      out_fill_r   <= ilir_pkg::FILL_W'(count_nxt);
      out_status_r <= status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_out   = out_value_r;
  assign out_fill_length = out_fill_r;
  assign out_status      = out_status_r;

endmodule

>>> hdl/ilir_decode.sv
// Request decoder for the indexed list core: range checks, position
// clamping, status and next fill count. Depends on ilir_pkg.
module ilir_decode (
  input  logic                              go,
  input  logic [ilir_pkg::FUNC_W-1:0]       func,
  input  logic [ilir_pkg::INDEX_W-1:0]      index,
  input  logic [ilir_pkg::VALUE_W-1:0]      value_in,
  input  logic [ilir_pkg::CNT_W-1:0]        count,
  output ilir_pkg::cell_cmd_t               cmd,
  output logic                              rd_en,
  output logic [ilir_pkg::STATUS_W-1:0]     status,
  output logic [ilir_pkg::CNT_W-1:0]        count_nxt
);

  logic                       in_range;
  logic [ilir_pkg::IDX_W-1:0] idx_low;
  logic [ilir_pkg::IDX_W-1:0] last_pos;
  logic [ilir_pkg::IDX_W-1:0] end_pos;

  // Index against current length
  assign in_range = index < ilir_pkg::INDEX_W'(count);
  assign idx_low  = index[ilir_pkg::IDX_W-1:0];
  assign end_pos  = ilir_pkg::IDX_W'(count);
  assign last_pos = ilir_pkg::IDX_W'(count - ilir_pkg::CNT_W'(1));

  // Decode the operation
  always_comb begin
    cmd.ins   = 1'b0;
    cmd.pop   = 1'b0;
    cmd.wr    = 1'b0;
    cmd.pos   = idx_low;
    cmd.word  = value_in[ilir_pkg::WORD_W-1:0];
    rd_en     = 1'b0;
    status    = ilir_pkg::ST_OK;
    count_nxt = count;
    unique case (func)
      ilir_pkg::OP_GET: begin
        if (in_range) begin
          rd_en = 1'b1;
        end else begin
          status = ilir_pkg::ST_INDEX_TOO_BIG;
        end
      end
      ilir_pkg::OP_SET: begin
        if (in_range) begin
          cmd.wr = go;
        end else begin
          status = ilir_pkg::ST_INDEX_TOO_BIG;
        end
      end
      ilir_pkg::OP_INSERT: begin
        if (count == ilir_pkg::CNT_W'(ilir_pkg::CAPACITY)) begin
          status = ilir_pkg::ST_FULL;
        end else begin
          // append when the index is past the end
          cmd.ins   = go;
          cmd.pos   = in_range ? idx_low : end_pos;
          count_nxt = count + ilir_pkg::CNT_W'(1);
        end
      end
      ilir_pkg::OP_POP: begin
        if (count == '0) begin
          status = ilir_pkg::ST_POP_EMPTY;
        end else begin
          // take the last entry when the index is past the end
          cmd.pop   = go;
          cmd.pos   = in_range ? idx_low : last_pos;
          rd_en     = 1'b1;
          count_nxt = count - ilir_pkg::CNT_W'(1);
        end
      end
      ilir_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/ilir_cell.sv
// One storage cell of the list: holds a word, loads from its left or right
// neighbor on a shift, and offers its word when selected. Depends on ilir_pkg.
module ilir_cell (
  input  logic                         clk,
  input  logic [ilir_pkg::IDX_W-1:0]   cell_pos,
  input  ilir_pkg::cell_cmd_t          cmd,
  input  logic [ilir_pkg::WORD_W-1:0]  left_word,
  input  logic [ilir_pkg::WORD_W-1:0]  right_word,
  output logic [ilir_pkg::WORD_W-1:0]  word,
  output logic [ilir_pkg::WORD_W-1:0]  rd_word
);

  logic [ilir_pkg::WORD_W-1:0] word_r;
  logic [ilir_pkg::WORD_W-1:0] word_nxt;
  logic                        hit;
  logic                        after;

  assign hit   = cell_pos == cmd.pos;
  assign after = cell_pos > cmd.pos;

  // Pick the next word: hold, take a neighbor, or take the request data
  always_comb begin
    word_nxt = word_r;
    if (cmd.ins) begin
      if (after) begin
        word_nxt = left_word;
      end else if (hit) begin
        word_nxt = cmd.word;
      end
    end else if (cmd.pop) begin
      if (after || hit) begin
        word_nxt = right_word;
      end
    end else if (cmd.wr && hit) begin
      word_nxt = cmd.word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  assign rd_word = hit ? word_r : '0;

endmodule

>>> test/tb.sv
// Testbench for indexed_list_insert_remove_core: directed table and random requests,
// each result checked against an in-bench model of the list or a typed-in result.
// Depends on ilir_pkg and the RTL of the core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilir_pkg::*;

  // Unused operation codes at both ends of the spare range
  localparam logic [FUNC_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 720;
  localparam int SETTLE_REQUESTS = 100;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int LONG_HOLD       = 80;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_ERROR_LINES = 40;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [FILL_W-1:0]   fill;
    logic [STATUS_W-1:0] status;
  } list_result_t;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    int                 reps;
    bit                 fixed;
    list_result_t       want;
  } list_step_t;

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func         = '0;
  logic [INDEX_W-1:0]  in_index        = '0;
  logic [VALUE_W-1:0]  in_value_in     = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [VALUE_W-1:0]  out_value_out;
  logic [FILL_W-1:0]   out_fill_length;
  logic [STATUS_W-1:0] out_status;

  // Model of the list contents
  logic [DATA_W-1:0] list_words [CAPACITY];
  int                list_len = 0;

  list_result_t pending_results [$];
  int           error_count   = 0;
  int           cycle_count   = 0;
  bit           settle_phase  = 1'b0;
  bit           hold_outputs  = 1'b0;
  int           no_gap_left   = 0;

  // Directed requests; fixed rows carry the result typed in
  list_step_t directed_steps [19] = '{
    '{OP_GET,      16'h0000, 32'h0000_0000,  1, 1'b1, '{32'h0, 5'd0,  ST_INDEX_TOO_BIG}},
    '{OP_SET,      16'h0000, 32'hFFFF_FFFF,  1, 1'b1, '{32'h0, 5'd0,  ST_INDEX_TOO_BIG}},
    '{OP_POP,      16'hFFFF, 32'h0000_0000,  1, 1'b1, '{32'h0, 5'd0,  ST_POP_EMPTY}},
    '{OP_SPARE_LO, 16'hFFFF, 32'hFFFF_FFFF,  1, 1'b1, '{32'h0, 5'd0,  ST_OK}},
    '{OP_SPARE_HI, 16'h0000, 32'h0000_0000,  1, 1'b1, '{32'h0, 5'd0,  ST_OK}},
    '{OP_INSERT,   16'hFFFF, 32'hFFFF_FFFF,  1, 1'b1, '{32'h0, 5'd1,  ST_OK}},
    '{OP_INSERT,   16'h0000, 32'h0000_0000,  1, 1'b1, '{32'h0, 5'd2,  ST_OK}},
    '{OP_GET,      16'h0001, 32'h0000_0000,  1, 1'b1, '{32'hFFFF_FFFF, 5'd2, ST_OK}},
    '{OP_GET,      16'hFFFF, 32'h0000_0000,  1, 1'b1, '{32'h0, 5'd2,  ST_INDEX_TOO_BIG}},
    '{OP_SET,      16'h0002, 32'h1234_5678,  1, 1'b1, '{32'h0, 5'd2,  ST_INDEX_TOO_BIG}},
    '{OP_SET,      16'h0000, 32'hA5A5_5A5A,  1, 1'b0, '0},
    '{OP_INSERT,   16'h0001, 32'h1000_0000, 14, 1'b0, '0},
    '{OP_INSERT,   16'h0000, 32'hDEAD_BEEF,  1, 1'b1, '{32'h0, 5'd16, ST_FULL}},
    '{OP_GET,      16'h000F, 32'h0000_0000,  1, 1'b0, '0},
    '{OP_POP,      16'hFFFF, 32'h0000_0000,  1, 1'b0, '0},
    '{OP_POP,      16'h0000, 32'h0000_0000,  1, 1'b0, '0},
    '{OP_INSERT,   16'h0000, 32'h5555_AAAA,  1, 1'b0, '0},
    '{OP_CLEAR,    16'h0007, 32'hFFFF_FFFF,  1, 1'b1, '{32'h0, 5'd0,  ST_OK}},
    '{OP_POP,      16'h0000, 32'h0000_0000,  1, 1'b1, '{32'h0, 5'd0,  ST_POP_EMPTY}}
  };

  indexed_list_insert_remove_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_index        (in_index),
    .in_value_in     (in_value_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value_out   (out_value_out),
    .out_fill_length (out_fill_length),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the list model and return its result
  function automatic list_result_t apply_request(input logic [FUNC_W-1:0] func,
                                                 input logic [INDEX_W-1:0] index,
                                                 input logic [VALUE_W-1:0] value);
    list_result_t      res;
    int                pos;
    logic [DATA_W-1:0] word;
    res  = '0;
    pos  = index;
    word = DATA_W'(value[WORD_W-1:0]);
    case (func)
      OP_GET: begin
        if (pos >= list_len) res.status = ST_INDEX_TOO_BIG;
        else res.value = VALUE_W'(list_words[pos]);
      end
      OP_SET: begin
        if (pos >= list_len) res.status = ST_INDEX_TOO_BIG;
        else list_words[pos] = word;
      end
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          if (pos > list_len) pos = list_len;
          for (int k = list_len; k > pos; k--) list_words[k] = list_words[k-1];
          list_words[pos] = word;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) begin
          res.status = ST_POP_EMPTY;
        end else begin
          if (pos >= list_len) pos = list_len - 1;
          res.value = VALUE_W'(list_words[pos]);
          for (int k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    res.fill = FILL_W'(list_len);
    return res;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    if (error_count < MAX_ERROR_LINES)
      $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Idle the request side now and then, except in calm stretches
  task automatic maybe_gap();
    if (settle_phase || no_gap_left > 0) begin
      if (no_gap_left > 0) no_gap_left--;
    end else if ($urandom_range(0, 29) == 0) begin
      no_gap_left = $urandom_range(10, 40);
    end else if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Offer one request, hold it until accepted, then record its expected result
  task automatic offer_request(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] index,
                               input logic [VALUE_W-1:0] value, input bit fixed,
                               input list_result_t want);
    list_result_t predicted;
    in_valid    <= 1'b1;
    in_func     <= func;
    in_index    <= index;
    in_value_in <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(func, index, value);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  // Operation mix leans toward growing, shrinking or neither
  function automatic logic [FUNC_W-1:0] pick_func(input int tilt);
    int roll;
    int ins_w;
    roll  = $urandom_range(0, 99);
    ins_w = (tilt == 0) ? 45 : (tilt == 1) ? 15 : 30;
    if (roll < ins_w) return OP_INSERT;
    if (roll < 60) return OP_POP;
    if (roll < 78) return OP_GET;
    if (roll < 95) return OP_SET;
    if (roll < 97) return OP_CLEAR;
    return FUNC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  // Request side: reset, directed table, then random requests
  initial begin
    int                 tilt;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    tilt = 2;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[s]) begin
      for (int r = 0; r < directed_steps[s].reps; r++) begin
        maybe_gap();
        offer_request(directed_steps[s].func, directed_steps[s].index,
                      directed_steps[s].value + VALUE_W'(r), directed_steps[s].fixed,
                      directed_steps[s].want);
      end
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) tilt = $urandom_range(0, 2);
      if (n == RANDOM_REQUESTS - SETTLE_REQUESTS) settle_phase = 1'b1;
      // Stall the result side for a long stretch while requests keep coming
      if (n == 150) begin
        hold_outputs = 1'b1;
        no_gap_left  = 60;
      end
      // Pause until every outstanding result has come back
      if (n == 400) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0:       index = INDEX_W'($urandom_range(0, 65535));
        1:       index = '1;
        default: index = INDEX_W'($urandom_range(0, CAPACITY + 1));
      endcase
      case ($urandom_range(0, 9))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase
      maybe_gap();
      offer_request(pick_func(tilt), index, value, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS indexed_list_insert_remove_core");
    end else begin
      $display("FAIL indexed_list_insert_remove_core");
    end
    $finish;
  end

  // Result side: alternate free runs and stall bursts, with one long hold
  initial begin
    @(posedge clk);
    forever begin
      if (settle_phase) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8))
          @(posedge clk);
        out_stall <= 1'b1;
        if (hold_outputs) begin
          hold_outputs = 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end else begin
          repeat ($urandom_range(1, 17)) @(posedge clk);
        end
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request waiting", out_value_out, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_value_out !== want.value)
          report_mismatch("value_out", out_value_out, want.value);
        if (out_fill_length !== want.fill)
          report_mismatch("fill_length", VALUE_W'(out_fill_length), VALUE_W'(want.fill));
        if (out_status !== want.status)
          report_mismatch("status", VALUE_W'(out_status), VALUE_W'(want.status));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL indexed_list_insert_remove_core");
      $finish;
    end
  end

endmodule
